// File: sv/fdt_pkg.sv
// fdt_pkg: shared types and constants for the truncating binary32 divider.
// No dependencies.
`timescale 1ns / 1ps
package fdt_pkg;
    localparam int FRAC_BITS = 23;
    localparam int EXP_BITS  = 8;
    localparam int BIAS      = 127;
    localparam int MAN_BITS  = FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;

    typedef enum logic [1:0] {
        CLS_DIV,
        CLS_CONST
    } cls_t;

    typedef struct packed {
        cls_t                  cls;
        logic [31:0]           const_bits;
        logic                  sign;
        logic [9:0]            expo;
        logic [MAN_BITS-1:0]   num;
        logic [MAN_BITS-1:0]   den;
    } job_t;
endpackage

// File: sv/fdt_front.sv
// fdt_front: classifies an operand pair into a constant result or a division job.
// Depends on fdt_pkg.
`timescale 1ns / 1ps
module fdt_front
(
    input  logic [31:0]   dividend_bits,
    input  logic [31:0]   divisor_bits,
    output fdt_pkg::job_t job
);
    logic a_zero;
    logic b_zero;
    logic a_pos;
    logic [9:0] er;

    always_comb
    begin
        a_zero = (dividend_bits[30:0] == 31'd0);
        b_zero = (divisor_bits[30:0] == 31'd0);
        a_pos  = !dividend_bits[31] && !a_zero &&
                 !((dividend_bits[30:23] == 8'hFF) && (dividend_bits[22:0] != 23'd0));
        er = {2'b00, dividend_bits[30:23]} - {2'b00, divisor_bits[30:23]} + 10'd127;
        job.sign = dividend_bits[31] ^ divisor_bits[31];
        job.expo = er;
        job.num  = {1'b1, dividend_bits[22:0]};
        job.den  = {1'b1, divisor_bits[22:0]};
        job.cls  = fdt_pkg::CLS_CONST;
        job.const_bits = 32'd0;
        if (b_zero)
        begin
            job.const_bits = a_zero ? fdt_pkg::QNAN_BITS : {!a_pos, 8'hFF, 23'd0};
        end
        else if (a_zero)
        begin
            job.const_bits = 32'd0;
        end
        else if (!er[9] && (er >= 10'd255))
        begin
            job.const_bits = {job.sign, 8'hFF, 23'd0};
        end
        else if (er[9] || (er == 10'd0))
        begin
            job.const_bits = {job.sign, 31'd0};
        end
        else
        begin
            job.cls = fdt_pkg::CLS_DIV;
        end
    end
endmodule

// File: sv/fdt_queue.sv
// fdt_queue: small FIFO between front and back.
// Depends on fdt_pkg.
`timescale 1ns / 1ps
module fdt_queue #(
    parameter int DEPTH = fdt_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fdt_pkg::job_t push_job,
    input  logic          pop,
    output logic          not_empty,
    output logic          full,
    output fdt_pkg::job_t head_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    fdt_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    assign head_job  = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (AW+1)'(DEPTH));
endmodule

// File: sv/fdt_back.sv
// fdt_back: pipelined restoring divider, one quotient bit per stage, and packing.
// Depends on fdt_pkg.
`timescale 1ns / 1ps
module fdt_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  fdt_pkg::job_t in_job,
    output logic          out_valid,
    output logic [31:0]   out_bits
);
    localparam int M  = fdt_pkg::MAN_BITS;
    localparam int NS = M;

    logic                vld_reg [NS+1];
    fdt_pkg::job_t       job_reg [NS+1];
    logic [M:0]          rem_reg [NS+1];
    logic [M-1:0]        q_reg   [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // num<<23 / den: first step compares num itself (top 24 bits), then shift in zeros
    always_ff @(posedge clk)
    begin
        job_reg[0] <= in_job;
        rem_reg[0] <= {1'b0, in_job.num};
        q_reg[0]   <= '0;
        for (int i = 1; i <= NS; i++)
        begin
            logic [M:0] r;
            logic [M:0] d;
            logic       ge;
            r  = (i == 1) ? rem_reg[i-1] : {rem_reg[i-1][M-1:0], 1'b0};
            d  = {1'b0, job_reg[i-1].den};
            ge = (r >= d);
            job_reg[i] <= job_reg[i-1];
            rem_reg[i] <= ge ? r - d : r;
            q_reg[i]   <= {q_reg[i-1][M-2:0], ge};
        end
    end

    logic [M-1:0] qn;
    logic [9:0]   en;
    always_comb
    begin
        qn = q_reg[NS];
        en = job_reg[NS].expo;
        if (!qn[M-1])
        begin
            qn = {qn[M-2:0], 1'b0};
            en = en - 10'd1;
        end
        if (job_reg[NS].cls == fdt_pkg::CLS_CONST)
        begin
            out_bits = job_reg[NS].const_bits;
        end
        else if (en == 10'd0)
        begin
            out_bits = {job_reg[NS].sign, 31'd0};
        end
        else
        begin
            out_bits = {job_reg[NS].sign, en[7:0], qn[M-2:0]};
        end
    end
    assign out_valid = vld_reg[NS];
endmodule

// File: sv/float32_divider_truncating_top.sv
// Channel | ports                               | handshake
// input   | dividend_bits, divisor_bits         | start & !busy
// result  | quotient_bits                       | done, one cycle
// One pair per cycle; a result passes the queue stage, the entry stage and the
// 24-stage divider pipeline. Reset is asynchronous, clears all valid state.
// The result side never stalls; busy rises only if QUEUE_DEPTH is 1 and the queue fills.
// Depends on fdt_pkg, fdt_front, fdt_queue, fdt_back.
`timescale 1ns / 1ps
module float32_divider_truncating_top #(
    parameter int QUEUE_DEPTH = fdt_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] dividend_bits,
    input  logic [31:0] divisor_bits,
    output logic        done,
    output logic [31:0] quotient_bits
);
    fdt_pkg::job_t f_job, h_job;
    logic ne, full, acc;

    assign busy = full;
    assign acc  = start && !busy;

    fdt_front u_front (.dividend_bits(dividend_bits), .divisor_bits(divisor_bits), .job(f_job));

    fdt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(acc), .push_job(f_job),
        .pop(ne), .not_empty(ne), .full(full), .head_job(h_job)
    );

    fdt_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(ne), .in_job(h_job),
        .out_valid(done), .out_bits(quotient_bits)
    );
endmodule

// File: sv/fdt_checker.sv
// fdt_checker: port-level assertions for the divider top, bound to it.
// Depends on float32_divider_truncating_top.
`timescale 1ns / 1ps
module fdt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] quotient_bits
);
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start, 26) && !$past(start, 27) |-> !done || $past(start, 26))
        else $error("done without start");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##26 done)
        else $error("result missing");
    a_zero_kn: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quotient_bits != 32'h7FC00001)
        else $error("bad nan");
endmodule

bind float32_divider_truncating_top fdt_checker u_fdt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .quotient_bits(quotient_bits)
);

// File: tb/sv/tb_float32_divider_truncating_top.sv
// Testbench for float32_divider_truncating_top: directed and random operand pairs,
// quotients predicted in a scoreboard class and checked in order against done words.
// Depends on fdt_pkg and the float32_divider_truncating_top RTL.
`timescale 1ns / 1ps
module tb_float32_divider_truncating_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    class quotient_scoreboard;
        logic [31:0] pending_quotients[$];
        int mismatches;

        function logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
            logic sign;
            int ea;
            int eb;
            int er;
            logic [47:0] num;
            logic [47:0] den;
            logic [47:0] q;
            if (b[30:0] == 31'd0)
            begin
                if (a[30:0] == 31'd0)
                    return fdt_pkg::QNAN_BITS;
                if (!a[31] && !(a[30:23] == 8'hFF && a[22:0] != 23'd0))
                    return 32'h7F800000;
                return 32'hFF800000;
            end
            if (a[30:0] == 31'd0)
                return 32'd0;
            sign = a[31] ^ b[31];
            ea = int'(a[30:23]);
            eb = int'(b[30:23]);
            er = ea - eb + fdt_pkg::BIAS;
            if (er >= 255)
                return {sign, 8'hFF, 23'd0};
            if (er <= 0)
                return {sign, 31'd0};
            num = {24'd0, 1'b1, a[22:0]} << fdt_pkg::FRAC_BITS;
            den = {24'd0, 1'b1, b[22:0]};
            q = num / den;
            if (!q[fdt_pkg::FRAC_BITS])
            begin
                q = q << 1;
                er = er - 1;
            end
            if (er <= 0)
                return {sign, 31'd0};
            return {sign, er[7:0], q[22:0]};
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending_quotients.push_back(predict_quotient(a, b));
        endfunction

        function void check_quotient(logic [31:0] actual);
            logic [31:0] expected;
            if (pending_quotients.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: quotient_bits=%h", actual);
                return;
            end
            expected = pending_quotients.pop_front();
            if (actual !== expected)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quotient mismatch: expected %h actual %h", expected, actual);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] dividend_bits;
    logic [31:0] divisor_bits;
    logic        done;
    logic [31:0] quotient_bits;

    quotient_scoreboard board;
    int idle_cycles;

    float32_divider_truncating_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .dividend_bits(dividend_bits),
        .divisor_bits(divisor_bits),
        .done(done),
        .quotient_bits(quotient_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_quotient(quotient_bits);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_float32_divider_truncating_top failed");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [31:0] a, logic [31:0] b, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        dividend_bits <= a;
        divisor_bits <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_operands(a, b);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        int r;
        v = $urandom();
        r = $urandom_range(0, 9);
        if (r == 0)
            v[30:0] = 31'd0;
        else if (r == 1)
            v[30:23] = 8'hFF;
        else if (r == 2)
            v[30:23] = 8'h00;
        else if (r < 7)
            v[30:23] = 8'($urandom_range(100, 154));
        return v;
    endfunction

    function automatic logic [31:0] near_exponent(logic [31:0] a, int offset);
        logic [31:0] v;
        int e;
        v = $urandom();
        e = int'(a[30:23]) - 127 + offset;
        if (e < 1)
            e = 1;
        if (e > 254)
            e = 254;
        v[30:23] = e[7:0];
        return v;
    endfunction

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] directed_a[$];
        logic [31:0] directed_b[$];
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        dividend_bits = 32'd0;
        divisor_bits = 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_a = '{32'h00000000, 32'h80000000, 32'h00000000, 32'h3F800000, 32'hBF800000,
                       32'h7FC00000, 32'h7F800000, 32'h00000000, 32'h80000000, 32'h3F800000,
                       32'h40400000, 32'h3F800000, 32'h7F7FFFFF, 32'h00800000, 32'h00800000,
                       32'h3F800000, 32'hFFFFFFFF, 32'h3FFFFFFF, 32'h3F800000, 32'h7F000000,
                       32'h3F800000, 32'h00000001};
        directed_b = '{32'h00000000, 32'h80000000, 32'h80000000, 32'h00000000, 32'h80000000,
                       32'h00000000, 32'h00000000, 32'hBF800000, 32'h40000000, 32'h3F800000,
                       32'hC0000000, 32'h40400000, 32'h00800000, 32'h7F7FFFFF, 32'h3F800000,
                       32'h3FFFFFFF, 32'h7FFFFFFF, 32'h3F800000, 32'h3F800001, 32'h3E800000,
                       32'h7F000000, 32'h00000001};
        foreach (directed_a[i])
            send_word(directed_a[i], directed_b[i], gap_length());

        for (int n = 0; n < 1200; n++)
        begin
            a = random_float();
            if ($urandom_range(0, 3) == 0)
                b = random_float();
            else
                b = near_exponent(a, $urandom_range(0, 3) - 1 + ($urandom_range(0, 7) == 0 ?
                    ($urandom_range(0, 1) ? 128 : -128) : 0));
            send_word(a, b, (n % 200 < 60) ? 0 : gap_length());
        end
        start <= 1'b0;

        while (board.pending_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb_float32_divider_truncating_top passed");
        else
            $display("tb_float32_divider_truncating_top failed");
        $finish;
    end
endmodule
